[design/hrtm_pkg.sv]
// Shared constants, payload types and helper functions of the Hamming ratio-test matcher.
`timescale 1ns / 1ps

package hrtm_pkg;

    // Store geometry.
    localparam int MAX_REFERENCES   = 1024;
    localparam int DESCRIPTOR_WORDS = 4;
    localparam int INPUT_WORDS      = 4;
    localparam int WORD_W           = 64;
    localparam int DESC_W           = WORD_W * DESCRIPTOR_WORDS;

    // Internal widths.
    localparam int IDX_W  = $clog2(MAX_REFERENCES);
    localparam int CNT_W  = $clog2(MAX_REFERENCES + 1);
    localparam int DIST_W = $clog2(DESC_W + 2);
    localparam int PC_W   = $clog2(WORD_W + 1);

    // Port field widths.
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int BEST_INDEX_W = 10;
    localparam int DISTANCE_W   = 9;

    localparam logic [DIST_W-1:0] NO_DISTANCE = DIST_W'(DESC_W + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Match status codes.
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RATIO_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] desc_word0;
        logic [WORD_W-1:0] desc_word1;
        logic [WORD_W-1:0] desc_word2;
        logic [WORD_W-1:0] desc_word3;
    } hrtm_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     match_status;
        logic [BEST_INDEX_W-1:0] best_index;
        logic [DISTANCE_W-1:0]   best_distance;
        logic [DISTANCE_W-1:0]   second_distance;
    } hrtm_out_t;

    // One queued command: operation plus the descriptor laid out as stored.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DESC_W-1:0] desc;
    } hrtm_cmd_t;

    // Lays the input words out as one stored descriptor; missing words are zero.
    function automatic logic [DESC_W-1:0] gather_desc(input hrtm_in_t item);
        logic [INPUT_WORDS-1:0][WORD_W-1:0] words;
        logic [DESC_W-1:0]                  desc;
        words = {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0};
        desc  = '0;
        for (int w = 0; w < DESCRIPTOR_WORDS; w++) begin
            if (w < INPUT_WORDS) begin
                desc[w*WORD_W +: WORD_W] = words[w % INPUT_WORDS];
            end
        end
        return desc;
    endfunction

    // Bit count of one 64-bit word as a tree of narrow adds.
    function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] x;
        x = value - ((value >> 1) & 64'h5555_5555_5555_5555);
        x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
        x = (x + (x >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[PC_W-1:0];
    endfunction

endpackage

[design/hamming_ratio_test_matcher_unit.sv]
// Top level of the brute-force Hamming matcher with ratio test.
`timescale 1ns / 1ps
// Clear and load words are each executed by the back end once at the head of the queue.
// A query scans the N stored references in order, N being the number of
// stored references, and the store memory delivers one descriptor per cycle.
// A query with fewer than two references skips the scan and goes straight to the result.
// Reset (aresetn, synchronous, active low) empties the store count, queue and output;
// the descriptor memory is not cleared and needs no clearing pass.

module hamming_ratio_test_matcher_unit
    import hrtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hrtm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output hrtm_out_t m_data
);

    // The front end takes each word, discards the unused operation code and
    // stores the command in a two-entry queue, so input words keep flowing, until the
    // queue is full, while the back end is busy scanning or waiting on the result channel.
    logic      cmd_valid;
    logic      cmd_ready;
    hrtm_cmd_t cmd;

    hrtm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The back end owns the reference store. A query streams every stored
    // entry through XOR, per-word bit counts, a distance sum and the best and
    // second-best tracker; on equal distances the earlier entry stays best.
    // The ratio test compares four times the best distance with three times
    // the second, and the result sits in an output register until taken.
    hrtm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[design/hrtm_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module hrtm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/hrtm_front.sv]
// Front end: accepts input words, drops unused operation codes and queues commands.
`timescale 1ns / 1ps

module hrtm_front
    import hrtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hrtm_in_t  s_data,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output hrtm_cmd_t cmd
);

    hrtm_cmd_t   queue_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        known_op;
    logic        push;
    logic        pop;
    hrtm_cmd_t   new_cmd;

    always_comb begin
        known_op = (s_data.operation inside {OP_CLEAR, OP_LOAD, OP_QUERY});
        s_ready  = (fill_reg != 2'd2);
        push     = s_valid && s_ready && known_op;
        cmd_valid = (fill_reg != 2'd0);
        pop      = cmd_valid && cmd_ready;
        cmd      = queue_reg[rd_ptr_reg];

        new_cmd.operation = s_data.operation;
        new_cmd.desc      = gather_desc(s_data);

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[design/hrtm_back.sv]
// Back end: runs clear, load and query commands against the reference store.
`timescale 1ns / 1ps

module hrtm_back
    import hrtm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  hrtm_cmd_t cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output hrtm_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [CNT_W-1:0]  scan_cnt_next;
    logic [DESC_W-1:0] query_reg;

    // Pipeline valid flags: RAM data, popcounts, summed distance.
    logic rd_v_reg, pc_v_reg, sum_v_reg;
    logic [DESCRIPTOR_WORDS-1:0][PC_W-1:0] pc_reg;
    logic [DIST_W-1:0] sum_reg, sum_next;

    logic [DIST_W-1:0] best_reg, second_reg;
    logic [IDX_W-1:0]  winner_idx_reg, cmp_idx_reg;
    logic              too_few_reg;

    logic              out_valid_reg;
    hrtm_out_t         out_data_reg, out_next;

    logic              take;
    logic              do_load;
    logic              issue;
    logic              finish;
    logic [DESC_W-1:0] rd_data;
    logic [DESC_W-1:0] diff;
    logic [DIST_W+1:0] best_x4, second_x3;

    hrtm_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_REFERENCES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (do_load),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cmd.desc),
        .rd_en   (issue),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        cmd_ready = (state_reg == ST_IDLE);
        take      = cmd_valid && cmd_ready;
        do_load   = take && (cmd.operation == OP_LOAD)
                    && (count_reg < CNT_W'(MAX_REFERENCES));
        issue     = (state_reg == ST_SCAN);
        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        finish    = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
        diff      = rd_data ^ query_reg;

        sum_next = '0;
        for (int w = 0; w < DESCRIPTOR_WORDS; w++) begin
            sum_next = sum_next + DIST_W'(pc_reg[w]);
        end

        best_x4   = {best_reg, 2'b00};
        second_x3 = {2'b00, second_reg} + {1'b0, second_reg, 1'b0};

        out_next.best_index      = BEST_INDEX_W'(winner_idx_reg);
        out_next.best_distance   = DISTANCE_W'(best_reg);
        out_next.second_distance = DISTANCE_W'(second_reg);
        if (too_few_reg) begin
            out_next.match_status = STATUS_TOO_FEW;
        end else if (best_x4 < second_x3) begin
            out_next.match_status = STATUS_ACCEPT;
        end else begin
            out_next.match_status = STATUS_RATIO_FAIL;
        end

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && (cmd.operation == OP_QUERY)) begin
                    state_next = (count_reg < CNT_W'(2)) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_next == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !pc_v_reg && !sum_v_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_v_reg      <= 1'b0;
            pc_v_reg      <= 1'b0;
            sum_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            pc_v_reg  <= rd_v_reg;
            sum_v_reg <= pc_v_reg;
            if (take && (cmd.operation == OP_CLEAR)) begin
                count_reg <= '0;
            end else if (do_load) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (take && (cmd.operation == OP_QUERY)) begin
            query_reg      <= cmd.desc;
            scan_cnt_reg   <= '0;
            cmp_idx_reg    <= '0;
            winner_idx_reg <= '0;
            if (count_reg < CNT_W'(2)) begin
                too_few_reg <= 1'b1;
                best_reg    <= '0;
                second_reg  <= '0;
            end else begin
                too_few_reg <= 1'b0;
                best_reg    <= NO_DISTANCE;
                second_reg  <= NO_DISTANCE;
            end
        end else begin
            if (issue) begin
                scan_cnt_reg <= scan_cnt_next;
            end
            if (sum_v_reg) begin
                cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
                if (sum_reg < best_reg) begin
                    second_reg     <= best_reg;
                    best_reg       <= sum_reg;
                    winner_idx_reg <= cmp_idx_reg;
                end else if (sum_reg < second_reg) begin
                    second_reg <= sum_reg;
                end
            end
        end

        for (int w = 0; w < DESCRIPTOR_WORDS; w++) begin
            pc_reg[w] <= popcount64(diff[w*WORD_W +: WORD_W]);
        end
        sum_reg <= sum_next;

        if (finish) begin
            out_data_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[bench/hamming_ratio_test_matcher_unit_tb.sv]
// Self-checking testbench for the Hamming ratio-test matcher with scripted and random traffic.
`timescale 1ns / 1ps

// Keeps its own copy of the reference store and works out each query's expected answer.
class nearest_ref_tracker;
    localparam int NONE_YET = hrtm_pkg::DESC_W + 1;

    logic [hrtm_pkg::DESC_W-1:0] refs [hrtm_pkg::MAX_REFERENCES];
    int unsigned                 ref_count;
    hrtm_pkg::hrtm_out_t         expected_matches [$];

    int unsigned mismatches, results_seen, queries, loads, dropped, clears, ignored;
    int unsigned accepts, ratio_fails, too_few, peak_count;

    function new();
        ref_count    = 0;
        mismatches   = 0;
        results_seen = 0;
        queries      = 0;
        loads        = 0;
        dropped      = 0;
        clears       = 0;
        ignored      = 0;
        accepts      = 0;
        ratio_fails  = 0;
        too_few      = 0;
        peak_count   = 0;
    endfunction

    // Nearest and second-nearest reference by bit distance; ties keep the earlier entry.
    function hrtm_pkg::hrtm_out_t predict_match(logic [hrtm_pkg::DESC_W-1:0] probe);
        hrtm_pkg::hrtm_out_t r;
        int unsigned         best, second, winner_idx, d;
        r = '0;
        if (ref_count < 2) begin
            r.match_status = hrtm_pkg::STATUS_TOO_FEW;
            too_few++;
            return r;
        end
        best       = NONE_YET;
        second     = NONE_YET;
        winner_idx = 0;
        for (int i = 0; i < ref_count; i++) begin
            d = $countones(probe ^ refs[i]);
            if (d < best) begin
                second     = best;
                best       = d;
                winner_idx = i;
            end else if (d < second) begin
                second = d;
            end
        end
        if (4 * best < 3 * second) begin
            r.match_status = hrtm_pkg::STATUS_ACCEPT;
            accepts++;
        end else begin
            r.match_status = hrtm_pkg::STATUS_RATIO_FAIL;
            ratio_fails++;
        end
        r.best_index      = hrtm_pkg::BEST_INDEX_W'(winner_idx);
        r.best_distance   = hrtm_pkg::DISTANCE_W'(best);
        r.second_distance = hrtm_pkg::DISTANCE_W'(second);
        return r;
    endfunction

    function void absorb_word(hrtm_pkg::hrtm_in_t w);
        logic [hrtm_pkg::DESC_W-1:0] desc;
        desc = {w.desc_word3, w.desc_word2, w.desc_word1, w.desc_word0};
        case (w.operation)
            hrtm_pkg::OP_CLEAR: begin
                ref_count = 0;
                clears++;
            end
            hrtm_pkg::OP_LOAD: begin
                if (ref_count < hrtm_pkg::MAX_REFERENCES) begin
                    refs[ref_count] = desc;
                    ref_count++;
                    loads++;
                    if (ref_count > peak_count) peak_count = ref_count;
                end else begin
                    dropped++;
                end
            end
            hrtm_pkg::OP_QUERY: begin
                expected_matches.insert(expected_matches.size(), predict_match(desc));
                queries++;
            end
            default: begin
                ignored++;
            end
        endcase
    endfunction

    function void flag(string what, hrtm_pkg::hrtm_out_t want, hrtm_pkg::hrtm_out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected status %0d index %0d best %0d second %0d",
                     $realtime, what, want.match_status, want.best_index,
                     want.best_distance, want.second_distance);
            $display("    got status %0d index %0d best %0d second %0d",
                     got.match_status, got.best_index, got.best_distance,
                     got.second_distance);
        end
    endfunction

    function void check_match(hrtm_pkg::hrtm_out_t got);
        hrtm_pkg::hrtm_out_t want;
        results_seen++;
        if (expected_matches.size() == 0) begin
            flag("result with no query pending", '0, got);
            return;
        end
        want = expected_matches.pop_front();
        if (got.match_status !== want.match_status || got.best_index !== want.best_index ||
            got.best_distance !== want.best_distance ||
            got.second_distance !== want.second_distance) begin
            flag("match mismatch", want, got);
        end
    endfunction
endclass

module hamming_ratio_test_matcher_unit_tb;
    import hrtm_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Rough number of random words after the scripted part.
    localparam int RANDOM_ITEMS = 500;

    // Loads in the closing burst.
    localparam int FINAL_LOADS = 48;

    // The slowest honest run stays far below this: about 600 words with the longest sender
    // gaps and a couple of hundred queries against stores of up to about 210 references
    // under the longest result stalls.
    localparam int CYCLE_LIMIT = 600_000;

    localparam logic [DESC_W-1:0] ALL_ONES  = {DESC_W{1'b1}};
    localparam logic [DESC_W-1:0] ALL_ZEROS = '0;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hrtm_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hrtm_out_t m_data;

    // When set, neither the sender nor the result sink inserts idle cycles.
    bit calm = 1'b0;

    int unsigned        cycle_count = 0;
    nearest_ref_tracker tracker;

    hamming_ratio_test_matcher_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog. A hang anywhere, including a result that never shows up, ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still pending",
                     cycle_count, tracker.expected_matches.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result monitor. Handshake signals are read right at the edge, so these are the values
    // that the block itself saw when the word moved.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_match(m_data);
        end
    end

    // Result sink back-pressure: random stall bursts between ready stretches.
    // During calm phases ready simply stays high.
    initial begin : result_sink
        int n;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    // Random descriptor; each word is now and then forced to all zeros or all ones so that
    // the extreme distances show up in the random traffic too.
    function automatic logic [DESC_W-1:0] rand_desc();
        logic [DESC_W-1:0] d;
        for (int w = 0; w < DESCRIPTOR_WORDS; w++) begin
            case ($urandom_range(0, 9))
                0:       d[w*WORD_W +: WORD_W] = '0;
                1:       d[w*WORD_W +: WORD_W] = '1;
                default: d[w*WORD_W +: WORD_W] = {$urandom, $urandom};
            endcase
        end
        return d;
    endfunction

    // Flips k randomly chosen bits (possibly the same one twice).
    function automatic logic [DESC_W-1:0] flip_bits(logic [DESC_W-1:0] d, int k);
        for (int i = 0; i < k; i++) begin
            d[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
        end
        return d;
    endfunction

    // Presents one word and holds it until the block takes it. Valid is left high on return
    // so that back-to-back words go out without a bubble.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DESC_W-1:0] desc);
        hrtm_in_t w;
        int       gap;
        w.operation  = op;
        w.desc_word0 = desc[0*WORD_W +: WORD_W];
        w.desc_word1 = desc[1*WORD_W +: WORD_W];
        w.desc_word2 = desc[2*WORD_W +: WORD_W];
        w.desc_word3 = desc[3*WORD_W +: WORD_W];
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.absorb_word(w);
    endtask

    // Holds the sender off until every pending query has been answered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_matches.size() != 0) @(posedge aclk);
    endtask

    // Query biased towards the stored references so that accepted matches are common.
    task automatic send_query();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && tracker.ref_count > 0) begin
            send_item(OP_QUERY, flip_bits(tracker.refs[$urandom_range(0, tracker.ref_count - 1)],
                                          $urandom_range(0, 40)));
        end else if (r < 8) begin
            send_item(OP_QUERY, rand_desc());
        end else begin
            send_item(OP_QUERY, (r == 8) ? ALL_ONES : ALL_ZEROS);
        end
    endtask

    initial begin : stimulus
        int                n, m, random_items;
        logic [OP_W-1:0]   op;
        logic [DESC_W-1:0] last_ref;

        tracker      = new();
        random_items = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- Scripted corner cases ----
        // Queries against an empty store and a store of one must both report too few.
        send_item(OP_QUERY, ALL_ONES);
        send_item(OP_UNUSED, ALL_ONES);
        send_item(OP_LOAD, ALL_ZEROS);
        send_item(OP_QUERY, ALL_ZEROS);
        // Two references, zero and the low seven bits set. A probe with three low bits sits
        // exactly on the ratio boundary (4*3 == 3*4), so it must fail; two low bits passes.
        send_item(OP_LOAD, DESC_W'(64'h7F));
        send_item(OP_QUERY, DESC_W'(64'h07));
        send_item(OP_QUERY, DESC_W'(64'h03));
        send_item(OP_QUERY, ALL_ONES);
        // Identical references: the first one keeps the best slot, distances tie.
        send_item(OP_CLEAR, ALL_ONES);
        send_item(OP_LOAD, ALL_ONES);
        send_item(OP_LOAD, ALL_ONES);
        send_item(OP_QUERY, ALL_ZEROS);   // both at the full 256-bit distance
        send_item(OP_QUERY, ALL_ONES);    // both at zero, and 0 < 0 fails the ratio test
        send_item(OP_LOAD, {4{64'hAAAA_AAAA_AAAA_AAAA}});
        send_item(OP_QUERY, {4{64'hAAAA_AAAA_AAAA_AAAA}});
        send_item(OP_UNUSED, ALL_ZEROS);
        // A clear leaves stale contents behind, but the store must behave as empty.
        send_item(OP_CLEAR, ALL_ZEROS);
        send_item(OP_QUERY, ALL_ONES);
        // Check that each input word lands in its own slice of the descriptor.
        send_item(OP_LOAD, {64'hFFFF_FFFF_FFFF_FFFF, 192'd0});
        send_item(OP_LOAD, {192'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        send_item(OP_QUERY, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
        wait_drained();

        // ---- Random traffic ----
        // Mostly well-formed episodes (clear, a few loads, some queries), with some noise
        // words mixed in. Calm episodes give stretches without any idle cycles.
        while (random_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    op = OP_W'($urandom_range(0, 3));
                    send_item(op, rand_desc());
                    if (op != OP_UNUSED) random_items++;
                end
            end else begin
                if ($urandom_range(0, 3) != 0 || tracker.ref_count > 150) begin
                    send_item(OP_CLEAR, rand_desc());
                    random_items++;
                end
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(0, 1);
                end else if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(17, 60);
                end else begin
                    n = $urandom_range(2, 16);
                end
                repeat (n) begin
                    // Near-copies of stored entries create ties and close second places.
                    if (tracker.ref_count > 0 && $urandom_range(0, 4) == 0) begin
                        send_item(OP_LOAD,
                                  flip_bits(tracker.refs[$urandom_range(0, tracker.ref_count - 1)],
                                            $urandom_range(0, 2)));
                    end else begin
                        send_item(OP_LOAD, rand_desc());
                    end
                    random_items++;
                end
                m = $urandom_range(1, 6);
                repeat (m) begin
                    send_query();
                    random_items++;
                end
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        // ---- Closing burst, no idling from here on ----
        // A fresh store filled back to back, then queries with the result side always ready.
        calm = 1'b1;
        wait_drained();
        send_item(OP_CLEAR, ALL_ZEROS);
        for (int i = 0; i < FINAL_LOADS; i++) begin
            send_item(OP_LOAD, rand_desc());
        end
        last_ref = tracker.refs[FINAL_LOADS - 1];
        send_item(OP_QUERY, last_ref);
        send_item(OP_QUERY, flip_bits(last_ref, 3));
        send_item(OP_QUERY, tracker.refs[0]);
        send_item(OP_QUERY, ALL_ZEROS);
        repeat (4) send_query();

        wait_drained();
        repeat (64) @(posedge aclk);

        $display("Ran %0d queries (%0d accepted, %0d failed the ratio test, %0d too few),",
                 tracker.queries, tracker.accepts, tracker.ratio_fails, tracker.too_few);
        $display("%0d stored loads, %0d dropped loads, %0d clears, %0d ignored words.",
                 tracker.loads, tracker.dropped, tracker.clears, tracker.ignored);
        $display("Store peaked at %0d references; %0d results checked, %0d mismatches.",
                 tracker.peak_count, tracker.results_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
design/hrtm_pkg.sv
design/hrtm_ram.sv
design/hrtm_front.sv
design/hrtm_back.sv
design/hamming_ratio_test_matcher_unit.sv
bench/hamming_ratio_test_matcher_unit_tb.sv
